// ===== hdl/gbns_pkg.sv =====
// Shared types and constants of the go-back-N segmenting sender.
`default_nettype none
package gbns_pkg;

    // Event codes as carried on the input kind field
    localparam logic [1:0] KIND_MSG     = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Timer commands on the closing item
    localparam logic [1:0] TC_LEAVE = 2'd0;
    localparam logic [1:0] TC_START = 2'd1;
    localparam logic [1:0] TC_STOP  = 2'd2;

    localparam int unsigned PREFIX_BYTES  = 4;
    localparam int unsigned HDR_BYTES     = 7;
    localparam logic [15:0] MAX_MSG_BYTES = 16'd65531;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] message_bytes;
        logic [31:0] ack_number;
        logic        ack_intact;
    } t_in;

    typedef struct packed {
        logic        packet_valid;
        logic [31:0] packet_seq;
        logic [9:0]  message_slot;
        logic [15:0] byte_offset;
        logic [6:0]  payload_bytes;
        logic [1:0]  timer_command;
        logic        message_accepted;
        logic        last;
    } t_out;

    // Classified event as queued between front and back
    typedef enum logic [1:0] {
        EV_MSG,
        EV_ACK,
        EV_TIMEOUT,
        EV_NONE
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind    kind;
        logic [15:0] stored_len;
        logic [31:0] ack_number;
        logic        ack_ok;
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FETCH,
        ST_SEND,
        ST_CLOSE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/gbns_front.sv =====
// Front end: classifies incoming events and queues them for the back end.
`default_nettype none
module gbns_front
    import gbns_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire t_in    i_in_data,
    output logic        o_ev_valid,
    input  wire logic   i_ev_pop,
    output t_event      o_ev
);

    t_event     r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_event     ev_c;
    logic       push;

    // classify the transfer
    always_comb begin
        ev_c.ack_number = i_in_data.ack_number;
        ev_c.ack_ok     = i_in_data.ack_intact;
        ev_c.stored_len = ((i_in_data.message_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES
                          : i_in_data.message_bytes) + 16'(PREFIX_BYTES);
        unique case (i_in_data.kind)
            KIND_MSG:     ev_c.kind = EV_MSG;
            KIND_ACK:     ev_c.kind = EV_ACK;
            KIND_TIMEOUT: ev_c.kind = EV_TIMEOUT;
            default:      ev_c.kind = EV_NONE;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_ev_valid = (r_cnt != 2'd0);
    assign o_ev       = r_q[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= ev_c;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_ev_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_ev_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gbns_back.sv =====
// Back end: window state, message ring and descriptor emission.
`default_nettype none
module gbns_back
    import gbns_pkg::*;
#(
    parameter int WINDOW        = 16,
    parameter int MESSAGE_SLOTS = 1024,
    parameter int PACKET_BYTES  = 128
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_ev_valid,
    output logic        o_ev_pop,
    input  wire t_event i_ev,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_out        o_out_data
);

    localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = $clog2(MESSAGE_SLOTS);
    localparam logic [15:0] MAXP = 16'(PACKET_BYTES - HDR_BYTES);

    t_state r_state, n_state;

    t_event        r_ev;
    logic [31:0]   r_base, r_next, r_send, r_stored;
    logic [WW-1:0] r_base_w, r_next_w;
    logic [SW-1:0] r_send_slot, r_wr_slot;
    logic [15:0]   r_off;
    logic          r_armed;
    logic [1:0]    r_tc;
    logic          r_acc;
    logic [15:0]   r_len;

    logic [15:0]   mem_len [MESSAGE_SLOTS];
    logic [31:0]   r_win_msg  [WINDOW];
    logic [SW-1:0] r_win_slot [WINDOW];
    logic [15:0]   r_win_off  [WINDOW];

    t_out r_out;
    logic r_out_valid;
    logic out_free;

    logic          room, ack_ok, ring_ok;
    logic [31:0]   ack_d, adv_sum;
    logic [15:0]   rem;
    logic          fin;

    assign out_free = !r_out_valid || !i_out_stall;
    assign room     = ((r_next - r_base) < 32'(WINDOW)) && (r_send != r_stored);
    assign ring_ok  = (r_stored - r_send) < 32'(MESSAGE_SLOTS);
    assign ack_ok   = r_ev.ack_ok && ((r_ev.ack_number - r_base) < (r_next - r_base));
    assign ack_d    = r_ev.ack_number - r_base + 32'd1;
    assign adv_sum  = 32'(r_base_w) + ack_d;
    assign rem      = (r_len > r_off) ? r_len - r_off : 16'd0;
    assign fin      = rem <= MAXP;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_ev_valid) n_state = ST_EVAL;
            ST_EVAL: begin
                if ((r_ev.kind == EV_MSG && ring_ok) || (r_ev.kind == EV_ACK && ack_ok)
                    || r_ev.kind == EV_TIMEOUT) n_state = ST_FETCH;
                else n_state = ST_CLOSE;
            end
            ST_FETCH: n_state = room ? ST_SEND : ST_CLOSE;
            ST_SEND:  if (out_free) n_state = ST_FETCH;
            ST_CLOSE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ev_pop = (r_state == ST_IDLE) && i_ev_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // message length ring
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL && r_ev.kind == EV_MSG && ring_ok) begin
            mem_len[r_wr_slot] <= r_ev.stored_len;
        end
        if (r_state == ST_FETCH) begin
            r_len <= mem_len[r_send_slot];
        end
    end

    // window record of each outstanding packet
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEND && out_free) begin
            r_win_msg[r_next_w]  <= r_send;
            r_win_slot[r_next_w] <= r_send_slot;
            r_win_off[r_next_w]  <= r_off;
        end
    end

    // sender state
    always_ff @(posedge i_clk) begin
        if (o_ev_pop) r_ev <= i_ev;
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_send      <= '0;
            r_stored    <= '0;
            r_base_w    <= '0;
            r_next_w    <= '0;
            r_send_slot <= '0;
            r_wr_slot   <= '0;
            r_off       <= '0;
            r_armed     <= 1'b0;
            r_tc        <= TC_LEAVE;
            r_acc       <= 1'b0;
        end else begin
            priority case (r_state)
                ST_EVAL: begin
                    unique case (r_ev.kind)
                        EV_MSG: begin
                            r_acc <= ring_ok;
                            r_tc  <= (ring_ok && !r_armed) ? TC_START : TC_LEAVE;
                            if (ring_ok) begin
                                r_stored  <= r_stored + 32'd1;
                                r_wr_slot <= (32'(r_wr_slot) == MESSAGE_SLOTS - 1) ? '0
                                             : r_wr_slot + SW'(1);
                                r_armed   <= 1'b1;
                            end
                        end
                        EV_ACK: begin
                            // stop or restart is settled once sending is done
                            r_acc <= 1'b0;
                            r_tc  <= ack_ok ? TC_START : TC_LEAVE;
                            if (ack_ok) begin
                                r_base   <= r_ev.ack_number + 32'd1;
                                r_base_w <= (adv_sum >= 32'(WINDOW))
                                            ? WW'(adv_sum - 32'(WINDOW)) : WW'(adv_sum);
                                r_armed  <= 1'b1;
                            end
                        end
                        EV_TIMEOUT: begin
                            if (r_next != r_base) begin
                                r_next      <= r_base;
                                r_next_w    <= r_base_w;
                                r_send      <= r_win_msg[r_base_w];
                                r_send_slot <= r_win_slot[r_base_w];
                                r_off       <= r_win_off[r_base_w];
                            end
                            r_acc   <= 1'b0;
                            r_tc    <= TC_START;
                            r_armed <= 1'b1;
                        end
                        EV_NONE: begin
                            r_acc <= 1'b0;
                            r_tc  <= TC_LEAVE;
                        end
                    endcase
                end
                // accepted ack: stop the timer if nothing is left outstanding
                ST_FETCH: if (!room && r_ev.kind == EV_ACK && r_base == r_next) begin
                    r_tc    <= TC_STOP;
                    r_armed <= 1'b0;
                end
                ST_SEND: if (out_free) begin
                    r_next   <= r_next + 32'd1;
                    r_next_w <= (32'(r_next_w) == WINDOW - 1) ? '0 : r_next_w + WW'(1);
                    if (fin) begin
                        r_send      <= r_send + 32'd1;
                        r_send_slot <= (32'(r_send_slot) == MESSAGE_SLOTS - 1) ? '0
                                       : r_send_slot + SW'(1);
                        r_off       <= '0;
                    end else begin
                        r_off <= r_off + MAXP;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEND && out_free) begin
            r_out.packet_valid     <= 1'b1;
            r_out.packet_seq       <= r_next;
            r_out.message_slot     <= 10'(r_send_slot);
            r_out.byte_offset      <= r_off;
            r_out.payload_bytes    <= fin ? rem[6:0] : MAXP[6:0];
            r_out.timer_command    <= TC_LEAVE;
            r_out.message_accepted <= 1'b0;
            r_out.last             <= 1'b0;
        end else if (r_state == ST_CLOSE && out_free) begin
            r_out.packet_valid     <= 1'b0;
            r_out.packet_seq       <= '0;
            r_out.message_slot     <= '0;
            r_out.byte_offset      <= '0;
            r_out.payload_bytes    <= '0;
            r_out.timer_command    <= r_tc;
            r_out.message_accepted <= r_acc;
            r_out.last             <= 1'b1;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_SEND || r_state == ST_CLOSE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== hdl/go_back_n_segmenting_sender.sv =====
// Go-back-N segmenting sender: top level joining front end and back end.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one event per
// transfer: new message, ack or timeout. A two-entry queue decouples input
// from the sender core, so events are taken while earlier ones still emit.
// Output channel (o_out_valid / i_out_stall / o_out_data) delivers packet
// descriptors followed by one closing item per event (last = 1).
// Each descriptor takes a ring read, then an emit; an event holds the core
// through pop, evaluate, N reads and emits for N descriptors, a final read
// and close, N at most WINDOW. The separate read step is set by the
// single-port read of the message length ring.
// Reset (i_rst_n low, synchronous) empties the queue and clears the window
// counters and timer state; the ring and window records need no clearing.
// When the receiver stalls, the output register holds its item and the
// core waits; once the queue fills, o_in_stall rises.
`default_nettype none
module go_back_n_segmenting_sender
    import gbns_pkg::*;
#(
    parameter int WINDOW        = 16,
    parameter int MESSAGE_SLOTS = 1024,
    parameter int PACKET_BYTES  = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic   ev_valid, ev_pop;
    t_event ev;

    gbns_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_ev_valid (ev_valid),
        .i_ev_pop   (ev_pop),
        .o_ev       (ev)
    );

    gbns_back #(
        .WINDOW        (WINDOW),
        .MESSAGE_SLOTS (MESSAGE_SLOTS),
        .PACKET_BYTES  (PACKET_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (ev_valid),
        .o_ev_pop    (ev_pop),
        .i_ev        (ev),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/tb_go_back_n_segmenting_sender.sv =====
// Testbench for the go-back-N segmenting sender: directed table, then random events.
`default_nettype none
module tb_go_back_n_segmenting_sender;
    import gbns_pkg::*;

    localparam int WIN        = 16;
    localparam int SLOTS      = 1024;
    localparam int PKT_BYTES  = 128;
    localparam int MAX_PAY    = PKT_BYTES - HDR_BYTES;
    localparam int N_RANDOM   = 150;
    localparam int CYCLE_CAP  = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    go_back_n_segmenting_sender #(
        .WINDOW(WIN), .MESSAGE_SLOTS(SLOTS), .PACKET_BYTES(PKT_BYTES)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // Predictor state
    logic [15:0] ring_len [SLOTS];
    logic [31:0] win_msg [WIN];
    logic [15:0] win_off [WIN];
    logic [31:0] base_seq, next_seq, send_msg, stored_msgs;
    logic [31:0] slice_off;
    logic        timer_on;

    t_out expected_items[$];
    int   fail_count;
    int   cycle_count;
    bit   no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report(input string what, input t_out got, input t_out want);
        $display("MISMATCH %s: got %p want %p", what, got, want);
        fail_count++;
    endtask

    function automatic t_out closing(input logic [1:0] tc, input logic acc);
        t_out c;
        c = '0;
        c.timer_command = tc;
        c.message_accepted = acc;
        c.last = 1'b1;
        return c;
    endfunction

    // Emit descriptors while the window has room
    function automatic void emit_packets();
        t_out d;
        logic [31:0] rem;
        int unsigned w;
        while ((next_seq - base_seq) < WIN && send_msg != stored_msgs) begin
            w = next_seq % WIN;
            rem = (ring_len[send_msg % SLOTS] > slice_off) ?
                  ring_len[send_msg % SLOTS] - slice_off : 0;
            win_msg[w] = send_msg;
            win_off[w] = slice_off[15:0];
            d = '0;
            d.packet_valid = 1'b1;
            d.packet_seq = next_seq;
            d.message_slot = 10'(send_msg % SLOTS);
            d.byte_offset = slice_off[15:0];
            if (rem <= MAX_PAY) begin
                d.payload_bytes = rem[6:0];
                send_msg++;
                slice_off = 0;
            end else begin
                d.payload_bytes = 7'(MAX_PAY);
                slice_off += MAX_PAY;
            end
            expected_items.push_back(d);
            next_seq++;
        end
    endfunction

    function automatic void predict_event(input t_in ev);
        logic [1:0]  tc;
        logic        acc;
        logic [15:0] len;
        tc = TC_LEAVE;
        acc = 1'b0;
        case (ev.kind)
            KIND_MSG: begin
                if ((stored_msgs - send_msg) < SLOTS) begin
                    len = (ev.message_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES
                                                             : ev.message_bytes;
                    ring_len[stored_msgs % SLOTS] = 16'(len + PREFIX_BYTES);
                    stored_msgs++;
                    acc = 1'b1;
                    emit_packets();
                    if (!timer_on) begin
                        tc = TC_START;
                        timer_on = 1'b1;
                    end
                end
            end
            KIND_ACK: begin
                if (ev.ack_intact && (ev.ack_number - base_seq) < (next_seq - base_seq)) begin
                    base_seq = ev.ack_number + 1;
                    emit_packets();
                    if (ev.ack_number + 1 == next_seq) begin
                        tc = TC_STOP;
                        timer_on = 1'b0;
                    end else begin
                        tc = TC_START;
                        timer_on = 1'b1;
                    end
                end
            end
            KIND_TIMEOUT: begin
                if (next_seq != base_seq) begin
                    next_seq = base_seq;
                    send_msg = win_msg[base_seq % WIN];
                    slice_off = win_off[base_seq % WIN];
                end
                emit_packets();
                tc = TC_START;
                timer_on = 1'b1;
            end
            default: ;
        endcase
        expected_items.push_back(closing(tc, acc));
    endfunction

    // Output side: random stall bursts and checking
    initial begin
        int burst;
        i_out_stall = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (expected_items.size() == 0) begin
                    report("unexpected transfer", o_out_data, '0);
                end else begin
                    t_out want;
                    want = expected_items.pop_front();
                    if (o_out_data !== want) report("result", o_out_data, want);
                end
            end
            if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // One input transfer, with a random idle burst beforehand; valid stays
    // high after the transfer until the next event or a drain drops it
    task automatic send_event(input t_in ev);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= ev;
        do @(posedge i_clk); while (o_in_stall);
        predict_event(ev);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_items.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in make_ev(input logic [1:0] k, input logic [15:0] b,
                                    input logic [31:0] a, input logic ok);
        t_in e;
        e.kind = k;
        e.message_bytes = b;
        e.ack_number = a;
        e.ack_intact = ok;
        return e;
    endfunction

    // Directed rows; chk marks rows whose single closing item is typed in
    typedef struct {
        t_in  ev;
        bit   chk;
        t_out want;
    } t_row;

    initial begin
        t_row rows[$];
        t_in  ev;
        int   r;
        fail_count = 0;
        cycle_count = 0;
        no_idle = 0;
        base_seq = 0; next_seq = 0; send_msg = 0; stored_msgs = 0;
        slice_off = 0; timer_on = 0;
        foreach (ring_len[k]) ring_len[k] = '0;
        foreach (win_msg[k]) begin
            win_msg[k] = '0;
            win_off[k] = '0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: unknown kind, ignored acks, timeout with nothing outstanding
        rows.push_back('{make_ev(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b1), 1, closing(TC_LEAVE, 0)});
        rows.push_back('{make_ev(KIND_ACK, 16'hFFFF, 32'h0, 1'b1), 1, closing(TC_LEAVE, 0)});
        rows.push_back('{make_ev(KIND_ACK, 16'h0, 32'hFFFF_FFFF, 1'b0), 1, closing(TC_LEAVE, 0)});
        rows.push_back('{make_ev(KIND_TIMEOUT, 16'h0, 32'h0, 1'b0), 1, closing(TC_START, 0)});
        // Messages: empty, one-packet edge, oversized saturating, maximum
        rows.push_back('{make_ev(KIND_MSG, 16'd0, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_MSG, 16'd117, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_MSG, 16'd118, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_MSG, 16'hFFFF, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_MSG, 16'd65531, 32'h0, 1'b0), 0, '0});
        // Corrupt ack in window, out of window ack, then good acks and timeouts
        rows.push_back('{make_ev(KIND_ACK, 16'h0, 32'd2, 1'b0), 1, closing(TC_LEAVE, 0)});
        rows.push_back('{make_ev(KIND_ACK, 16'h0, 32'd500, 1'b1), 1, closing(TC_LEAVE, 0)});
        rows.push_back('{make_ev(KIND_ACK, 16'h0, 32'd2, 1'b1), 0, '0});
        rows.push_back('{make_ev(KIND_TIMEOUT, 16'h0, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_ACK, 16'h0, 32'd10, 1'b1), 0, '0});
        rows.push_back('{make_ev(KIND_TIMEOUT, 16'h0, 32'h0, 1'b0), 0, '0});
        rows.push_back('{make_ev(KIND_MSG, 16'd1, 32'h0, 1'b0), 0, '0});

        foreach (rows[k]) begin
            if (rows[k].chk) begin
                wait_drained();
                send_event(rows[k].ev);
                void'(expected_items.pop_back());
                expected_items.push_back(rows[k].want);
            end else begin
                send_event(rows[k].ev);
            end
        end

        // Sender pause: let every expected result arrive
        wait_drained();

        // Random part: mostly small messages and in-window acks
        for (r = 0; r < N_RANDOM; r++) begin
            int pick;
            if (r > N_RANDOM * 4 / 5) no_idle = 1;
            pick = $urandom_range(0, 99);
            ev = make_ev(KIND_MSG, 16'($urandom_range(0, 400)), $urandom, 1'b1);
            if (pick < 5) begin
                ev.message_bytes = $urandom;
            end else if (pick < 45) begin
                ev.kind = KIND_ACK;
                if (next_seq != base_seq && $urandom_range(0, 3) != 0)
                    ev.ack_number = base_seq + $urandom_range(0, next_seq - base_seq - 1);
                ev.ack_intact = ($urandom_range(0, 7) != 0);
            end else if (pick < 55) begin
                ev.kind = KIND_TIMEOUT;
                ev.ack_intact = $urandom;
            end else if (pick < 58) begin
                ev.kind = 2'd3;
                ev.message_bytes = $urandom;
            end
            send_event(ev);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && expected_items.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
